// ===== design/chmod_mode_string_parser_defines.svh =====
// ----------------------------------------------------------------------------
// chmod mode string parser assertion macros
// shared concurrent assertion helpers, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef CHMOD_MODE_STRING_PARSER_DEFINES_SVH
`define CHMOD_MODE_STRING_PARSER_DEFINES_SVH

// same-cycle implication
`define CMSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsp_pkg
// types, character codes and clause helpers of the chmod mode string parser
// ----------------------------------------------------------------------------
package cmsp_pkg;

  localparam int unsigned ModeW = 12;

  typedef logic [ModeW-1:0] mode_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_e;

  typedef enum logic {
    PH_WHO  = 1'b0,
    PH_PERM = 1'b1
  } phase_e;

  // character codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChBigX  = 8'h58;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;

  localparam mode_t ExecAll = 12'o0111;
  localparam mode_t Sticky  = 12'o1000;

  // who bits: [2] user, [1] group, [0] other
  localparam logic [2:0] WhoAll = 3'b111;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic       last_char;
    mode_t      start_mode;
    logic       target_is_dir;
  } in_word_t;

  function automatic mode_t by_who(logic [2:0] who, mode_t ub, mode_t gb, mode_t ob);
    mode_t r;
    r = '0;
    if (who[2]) r = r | ub;
    if (who[1]) r = r | gb;
    if (who[0]) r = r | ob;
    return r;
  endfunction

  function automatic mode_t apply_clause(mode_t mode, logic [2:0] who, op_e op,
                                         mode_t perms);
    mode_t wm;
    mode_t r;
    wm = by_who(who, 12'o4700, 12'o2070, 12'o0007) | Sticky;
    case (op)
      OP_ADD:  r = mode | perms;
      OP_SUB:  r = mode & ~perms;
      OP_SET:  r = (mode & ~wm) | perms;
      default: r = mode;
    endcase
    return r;
  endfunction

endpackage

// ===== design/chmod_mode_string_parser.sv =====
// ----------------------------------------------------------------------------
// chmod mode string parser
// parses an octal or symbolic chmod mode string, one character per word
// ----------------------------------------------------------------------------
// result path: the last character passes through the input register, then its
//   result word is loaded into the result register, which it waits for while
//   an earlier result word is still held
// throughput: one character per cycle; a last character waits in the input
//   register only while an earlier result word is still held on the master side
// reset: rst_ni async low clears both valid flags and all parse state
// ----------------------------------------------------------------------------
`include "chmod_mode_string_parser_defines.svh"

module chmod_mode_string_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // char_code[7:0], start_mode[19:8], target_is_dir[20]
  input  logic        s_axis_tuser_i,  // first_char
  input  logic        s_axis_tlast_i,  // last_char
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // result_mode[11:0], invalid[12]
  output logic        m_axis_tuser_o   // was_octal
);

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  cmsp_pkg::in_word_t s1_q;
  logic               s1_valid_q;
  logic               out_free;
  logic               s1_fire;

  // the result register can take a new word when empty or being drained
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;
  // a non-final character only updates state, so it never waits on the output
  assign s1_fire  = s1_valid_q && (!s1_q.last_char || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_q.char_code     <= s_axis_tdata_i[7:0];
      s1_q.start_mode    <= s_axis_tdata_i[19:8];
      s1_q.target_is_dir <= s_axis_tdata_i[20];
      s1_q.first_char    <= s_axis_tuser_i;
      s1_q.last_char     <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // parse state
  // --------------------------------------------------------------------------
  cmsp_pkg::mode_t   running_q, running_d;
  logic [2:0]        who_q, who_d;
  cmsp_pkg::op_e     op_q, op_d;
  cmsp_pkg::mode_t   perm_q, perm_d;
  cmsp_pkg::phase_e  phase_q, phase_d;
  logic              err_q, err_d;
  cmsp_pkg::mode_t   oct_q, oct_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              alloct_q, alloct_d;
  logic              dir_q, dir_d;

  // result of the current character, valid when it is the last one
  cmsp_pkg::mode_t   res_mode;
  logic              res_invalid;
  logic              res_octal;

  always_comb begin
    logic [7:0]      c;
    cmsp_pkg::op_e   op_c;
    cmsp_pkg::mode_t x_bits;
    cmsp_pkg::mode_t fin_mode;
    logic            bad;
    logic            is_oct;

    c = s1_q.char_code;

    // a first character restarts the string from the sampled target mode
    if (s1_q.first_char) begin
      running_d = s1_q.start_mode;
      who_d     = '0;
      op_d      = cmsp_pkg::OP_NONE;
      perm_d    = '0;
      phase_d   = cmsp_pkg::PH_WHO;
      err_d     = 1'b0;
      oct_d     = '0;
      cnt_d     = '0;
      alloct_d  = 1'b1;
      dir_d     = s1_q.target_is_dir;
    end else begin
      running_d = running_q;
      who_d     = who_q;
      op_d      = op_q;
      perm_d    = perm_q;
      phase_d   = phase_q;
      err_d     = err_q;
      oct_d     = oct_q;
      cnt_d     = cnt_q;
      alloct_d  = alloct_q;
      dir_d     = dir_q;
    end

    // octal tracking: length saturates at seven, digits shift in
    if (cnt_d != 3'd7) cnt_d = cnt_d + 3'd1;
    is_oct = (c >= cmsp_pkg::ChZero) && (c <= cmsp_pkg::ChSeven);
    if (is_oct) oct_d = {oct_d[8:0], c[2:0]};
    alloct_d = alloct_d && is_oct;

    case (c)
      cmsp_pkg::ChPlus:  op_c = cmsp_pkg::OP_ADD;
      cmsp_pkg::ChMinus: op_c = cmsp_pkg::OP_SUB;
      cmsp_pkg::ChEq:    op_c = cmsp_pkg::OP_SET;
      default:           op_c = cmsp_pkg::OP_NONE;
    endcase

    // X grants execute on a directory or when some execute bit is already set
    x_bits = (dir_d || ((running_d & cmsp_pkg::ExecAll) != '0))
           ? cmsp_pkg::by_who(who_d, 12'o0100, 12'o0010, 12'o0001) : '0;

    // symbolic clause parsing, frozen once an error is seen
    if (!err_d) begin
      if (phase_d != cmsp_pkg::PH_PERM) begin
        case (c)
          cmsp_pkg::ChU: who_d = who_d | 3'b100;
          cmsp_pkg::ChG: who_d = who_d | 3'b010;
          cmsp_pkg::ChO: who_d = who_d | 3'b001;
          cmsp_pkg::ChA: who_d = cmsp_pkg::WhoAll;
          default: begin
            if (op_c != cmsp_pkg::OP_NONE) begin
              if (who_d == '0) who_d = cmsp_pkg::WhoAll;
              op_d    = op_c;
              perm_d  = '0;
              phase_d = cmsp_pkg::PH_PERM;
            end else begin
              err_d = 1'b1;
            end
          end
        endcase
      end else if (c == cmsp_pkg::ChComma || op_c != cmsp_pkg::OP_NONE) begin
        // close the clause; an op character opens the next one for all
        running_d = cmsp_pkg::apply_clause(running_d, who_d, op_d, perm_d);
        perm_d    = '0;
        if (op_c != cmsp_pkg::OP_NONE) begin
          who_d   = cmsp_pkg::WhoAll;
          op_d    = op_c;
          phase_d = cmsp_pkg::PH_PERM;
        end else begin
          who_d   = '0;
          op_d    = cmsp_pkg::OP_NONE;
          phase_d = cmsp_pkg::PH_WHO;
        end
      end else begin
        case (c)
          cmsp_pkg::ChR:
            perm_d = perm_d | cmsp_pkg::by_who(who_d, 12'o0400, 12'o0040, 12'o0004);
          cmsp_pkg::ChW:
            perm_d = perm_d | cmsp_pkg::by_who(who_d, 12'o0200, 12'o0020, 12'o0002);
          cmsp_pkg::ChX:
            perm_d = perm_d | cmsp_pkg::by_who(who_d, 12'o0100, 12'o0010, 12'o0001);
          cmsp_pkg::ChBigX:
            perm_d = perm_d | x_bits;
          cmsp_pkg::ChS:
            perm_d = perm_d | cmsp_pkg::by_who(who_d, 12'o4000, 12'o2000, 12'o0000);
          cmsp_pkg::ChT:
            perm_d = perm_d | cmsp_pkg::Sticky;
          default:
            err_d = 1'b1;
        endcase
      end
    end

    // result: one to four octal digits win, else the symbolic outcome,
    // with the open clause applied but not committed
    bad      = err_d;
    fin_mode = running_d;
    if (!bad) begin
      if (phase_d == cmsp_pkg::PH_PERM) begin
        fin_mode = cmsp_pkg::apply_clause(running_d, who_d, op_d, perm_d);
      end else if (who_d != '0) begin
        bad = 1'b1;  // string ends inside who letters
      end
    end

    if (alloct_d && (cnt_d <= 3'd4)) begin
      res_mode    = oct_d;
      res_invalid = 1'b0;
      res_octal   = 1'b1;
    end else begin
      res_mode    = bad ? '0 : fin_mode;
      res_invalid = bad;
      res_octal   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      who_q     <= '0;
      op_q      <= cmsp_pkg::OP_NONE;
      perm_q    <= '0;
      phase_q   <= cmsp_pkg::PH_WHO;
      err_q     <= 1'b0;
      oct_q     <= '0;
      cnt_q     <= '0;
      alloct_q  <= 1'b1;
      dir_q     <= 1'b0;
    end else if (s1_fire) begin
      running_q <= running_d;
      who_q     <= who_d;
      op_q      <= op_d;
      perm_q    <= perm_d;
      phase_q   <= phase_d;
      err_q     <= err_d;
      oct_q     <= oct_d;
      cnt_q     <= cnt_d;
      alloct_q  <= alloct_d;
      dir_q     <= dir_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic            out_valid_q;
  cmsp_pkg::mode_t out_mode_q;
  logic            out_invalid_q;
  logic            out_octal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_q.last_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && s1_q.last_char) begin
      out_mode_q    <= res_mode;
      out_invalid_q <= res_invalid;
      out_octal_q   <= res_octal;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_invalid_q, out_mode_q};
  assign m_axis_tuser_o  = out_octal_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CMSP_ASSERT_NOW(a_invalid_clean, out_valid_q && out_invalid_q, (out_mode_q == '0) && !out_octal_q, "invalid result carries mode bits or octal flag")
  `CMSP_ASSERT_NOW(a_perm_has_op, phase_q == cmsp_pkg::PH_PERM, op_q != cmsp_pkg::OP_NONE, "perm phase without a pending op")
  `CMSP_ASSERT_NOW(a_who_no_perms, phase_q == cmsp_pkg::PH_WHO, perm_q == '0, "clause perms collected outside perm phase")
  `CMSP_ASSERT_NEXT(a_result_from_last, s1_fire && !s1_q.last_char && !out_valid_q, !out_valid_q, "result produced by a non-final character")

endmodule

// ===== sim/chmod_mode_string_parser_tb.sv =====
// ----------------------------------------------------------------------------
// chmod mode string parser testbench
// feeds octal, symbolic, broken and noise mode strings one character word at
// a time with random gaps on both sides, and checks each result word against a
// cycle-free model of the parser in this bench or against a typed table row
// ----------------------------------------------------------------------------
module chmod_mode_string_parser_tb;

  // result word fields as compared, lowest field last
  typedef struct packed {
    cmsp_pkg::mode_t mode;
    logic            bad;
    logic            octal;
  } mode_result_t;

  // one row of the directed table; want_* only used where typed is set
  typedef struct packed {
    logic [7:0]      ch;
    logic            first;
    logic            last;
    cmsp_pkg::mode_t smode;
    logic            dir;
    logic            typed;
    cmsp_pkg::mode_t want_mode;
    logic            want_bad;
    logic            want_octal;
  } char_row_t;

  localparam int              NumRows   = 25;
  localparam int              RandChars = 1950;
  localparam cmsp_pkg::mode_t ModeFull  = 12'o7777;
  localparam cmsp_pkg::mode_t ModeZero  = 12'o0000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data  = '0;
  logic        s_first = 1'b0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  bit sink_steady = 1'b0;

  // model state of the parser
  cmsp_pkg::mode_t  run_mode;
  logic [2:0]       who_acc;
  cmsp_pkg::op_e    pend_op;
  cmsp_pkg::mode_t  perm_acc;
  cmsp_pkg::phase_e phase;
  logic             err_sticky;
  cmsp_pkg::mode_t  oct_val;
  logic [2:0]       len_cnt;
  logic             only_digits;
  logic             is_dir;

  mode_result_t expected_modes[$];
  logic [7:0]   str_q[$];
  logic [7:0]   who_set[4];
  logic [7:0]   op_set[3];
  logic [7:0]   perm_set[6];
  char_row_t    rows[NumRows];

  int chars_sent    = 0;
  int strings_sent  = 0;
  int results_seen  = 0;
  int octal_seen    = 0;
  int invalid_seen  = 0;
  int mismatch_cnt  = 0;

  chmod_mode_string_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),      // char_code[7:0], start_mode[19:8], target_is_dir[20]
    .s_axis_tuser_i (s_first),     // first_char
    .s_axis_tlast_i (s_last),      // last_char
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o), // result_mode[11:0], invalid[12]
    .m_axis_tuser_o (m_axis_tuser_o)  // was_octal
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model of the parser
  // ---------------------------------------------------------------------------

  function automatic cmsp_pkg::mode_t class_bits(logic [2:0] who, cmsp_pkg::mode_t ub,
                                                 cmsp_pkg::mode_t gb, cmsp_pkg::mode_t ob);
    cmsp_pkg::mode_t r;
    r = ModeZero;
    if (who[2]) r |= ub;
    if (who[1]) r |= gb;
    if (who[0]) r |= ob;
    return r;
  endfunction

  function automatic cmsp_pkg::mode_t fold_clause(cmsp_pkg::mode_t m, logic [2:0] who,
                                                  cmsp_pkg::op_e op,
                                                  cmsp_pkg::mode_t perms);
    cmsp_pkg::mode_t keep_out;
    keep_out = class_bits(who, 12'o4700, 12'o2070, 12'o0007) | cmsp_pkg::Sticky;
    case (op)
      cmsp_pkg::OP_ADD: return m | perms;
      cmsp_pkg::OP_SUB: return m & ~perms;
      cmsp_pkg::OP_SET: return (m & ~keep_out) | perms;
      default:          return m;
    endcase
  endfunction

  function automatic cmsp_pkg::op_e char_op(logic [7:0] c);
    if (c == cmsp_pkg::ChPlus)  return cmsp_pkg::OP_ADD;
    if (c == cmsp_pkg::ChMinus) return cmsp_pkg::OP_SUB;
    if (c == cmsp_pkg::ChEq)    return cmsp_pkg::OP_SET;
    return cmsp_pkg::OP_NONE;
  endfunction

  task automatic clear_parse();
    run_mode    = ModeZero;
    who_acc     = 3'b000;
    pend_op     = cmsp_pkg::OP_NONE;
    perm_acc    = ModeZero;
    phase       = cmsp_pkg::PH_WHO;
    err_sticky  = 1'b0;
    oct_val     = ModeZero;
    len_cnt     = 3'd0;
    only_digits = 1'b1;
    is_dir      = 1'b0;
  endtask

  // op character opens a clause; an empty who means all
  task automatic begin_clause(cmsp_pkg::op_e op);
    if (who_acc == 3'b000) who_acc = cmsp_pkg::WhoAll;
    pend_op  = op;
    perm_acc = ModeZero;
    phase    = cmsp_pkg::PH_PERM;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic first, input logic last,
                            input cmsp_pkg::mode_t smode, input logic dir,
                            output logic has_res, output mode_result_t res);
    cmsp_pkg::op_e   op;
    logic            bad;
    cmsp_pkg::mode_t m;
    if (first) begin
      clear_parse();
      run_mode = smode;
      is_dir   = dir;
    end
    if (len_cnt < 3'd7) len_cnt++;
    if (c >= cmsp_pkg::ChZero && c <= cmsp_pkg::ChSeven) oct_val = {oct_val[8:0], c[2:0]};
    else only_digits = 1'b0;

    if (!err_sticky) begin
      op = char_op(c);
      if (phase != cmsp_pkg::PH_PERM) begin
        case (c)
          cmsp_pkg::ChU: who_acc[2] = 1'b1;
          cmsp_pkg::ChG: who_acc[1] = 1'b1;
          cmsp_pkg::ChO: who_acc[0] = 1'b1;
          cmsp_pkg::ChA: who_acc = cmsp_pkg::WhoAll;
          default: begin
            if (op != cmsp_pkg::OP_NONE) begin_clause(op);
            else err_sticky = 1'b1;
          end
        endcase
      end else if (c == cmsp_pkg::ChComma || op != cmsp_pkg::OP_NONE) begin
        // clause ends; a following op starts the next one at once
        run_mode = fold_clause(run_mode, who_acc, pend_op, perm_acc);
        who_acc  = 3'b000;
        pend_op  = cmsp_pkg::OP_NONE;
        perm_acc = ModeZero;
        phase    = cmsp_pkg::PH_WHO;
        if (op != cmsp_pkg::OP_NONE) begin_clause(op);
      end else begin
        case (c)
          cmsp_pkg::ChR:
            perm_acc |= class_bits(who_acc, 12'o0400, 12'o0040, 12'o0004);
          cmsp_pkg::ChW:
            perm_acc |= class_bits(who_acc, 12'o0200, 12'o0020, 12'o0002);
          cmsp_pkg::ChX:
            perm_acc |= class_bits(who_acc, 12'o0100, 12'o0010, 12'o0001);
          cmsp_pkg::ChBigX: begin
            // conditional execute: directory or some execute bit already set
            if (is_dir || (run_mode & cmsp_pkg::ExecAll) != ModeZero)
              perm_acc |= class_bits(who_acc, 12'o0100, 12'o0010, 12'o0001);
          end
          cmsp_pkg::ChS:
            perm_acc |= class_bits(who_acc, 12'o4000, 12'o2000, ModeZero);
          cmsp_pkg::ChT:
            perm_acc |= cmsp_pkg::Sticky;
          default:
            err_sticky = 1'b1;
        endcase
      end
    end

    has_res = last;
    res     = '0;
    if (last) begin
      if (only_digits && len_cnt >= 3'd1 && len_cnt <= 3'd4) begin
        res = '{oct_val, 1'b0, 1'b1};
      end else begin
        // the open clause is folded into the result only, not into the state
        bad = err_sticky;
        m   = run_mode;
        if (!bad) begin
          if (phase == cmsp_pkg::PH_PERM) m = fold_clause(m, who_acc, pend_op, perm_acc);
          else if (who_acc != 3'b000) bad = 1'b1;
        end
        res = '{bad ? ModeZero : m, bad, 1'b0};
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic first, input logic last,
                           input cmsp_pkg::mode_t smode, input logic dir,
                           input logic typed, input mode_result_t want, input int gap);
    logic         has_res;
    mode_result_t res;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {3'b000, dir, smode, c};
    s_first <= first;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_char(c, first, last, smode, dir, has_res, res);
    if (has_res) expected_modes.push_back(typed ? want : res);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // octal, well-formed symbolic, damaged symbolic or plain noise
  task automatic fill_mode_string();
    int         kind;
    int         n;
    int         k;
    int         pos;
    logic [7:0] b;
    str_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      repeat (n) str_q.push_back(cmsp_pkg::ChZero + 8'($urandom_range(0, 7)));
    end else if (kind < 90) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        // later clauses either follow a comma or chain straight on an op
        if (k == 0 || $urandom_range(0, 99) < 70) begin
          if (k > 0) str_q.push_back(cmsp_pkg::ChComma);
          repeat ($urandom_range(0, 3)) str_q.push_back(who_set[$urandom_range(0, 3)]);
        end
        str_q.push_back(op_set[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 4)) str_q.push_back(perm_set[$urandom_range(0, 5)]);
      end
      if (kind >= 75) begin
        pos = $urandom_range(0, str_q.size() - 1);
        case ($urandom_range(0, 2))
          0: str_q[pos] = 8'($urandom_range(0, 255));
          1: str_q[pos] = cmsp_pkg::ChComma;
          default: begin
            // cut the string and end it on a who letter
            while (str_q.size() > pos + 1) b = str_q.pop_back();
            str_q.push_back(who_set[$urandom_range(0, 3)]);
          end
        endcase
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: bursts of ready, short stalls, now and then a long one
  initial begin
    int n;
    @(negedge clk_i);
    forever begin
      if (sink_steady || $urandom_range(0, 99) < 65) begin
        m_ready <= 1'b1;
        n = $urandom_range(1, 12);
      end else begin
        m_ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (n) @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_result
    mode_result_t got;
    mode_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = '{m_axis_tdata_o[11:0], m_axis_tdata_o[12], m_axis_tuser_o};
      results_seen++;
      if (expected_modes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word: mode %o invalid %b octal %b",
                   got.mode, got.bad, got.octal);
      end else begin
        want = expected_modes.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected mode %o invalid %b octal %b, got mode %o invalid %b octal %b",
                     results_seen, want.mode, want.bad, want.octal,
                     got.mode, got.bad, got.octal);
        end
        if (want.octal) octal_seen++;
        if (want.bad) invalid_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int              i;
    int              j;
    int              r;
    int              gap;
    bit              quiet;
    logic            fst;
    logic            lst;
    cmsp_pkg::mode_t smode;

    who_set  = '{cmsp_pkg::ChU, cmsp_pkg::ChG, cmsp_pkg::ChO, cmsp_pkg::ChA};
    op_set   = '{cmsp_pkg::ChPlus, cmsp_pkg::ChMinus, cmsp_pkg::ChEq};
    perm_set = '{cmsp_pkg::ChR, cmsp_pkg::ChW, cmsp_pkg::ChX, cmsp_pkg::ChBigX,
                 cmsp_pkg::ChS, cmsp_pkg::ChT};

    rows = '{
      // a digit before any first character continues the reset string
      '{cmsp_pkg::ChZero,  1'b0, 1'b1, ModeZero, 1'b0, 1'b1, ModeZero, 1'b0, 1'b1},
      // four sevens: largest octal value
      '{cmsp_pkg::ChSeven, 1'b1, 1'b0, ModeFull, 1'b1, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b0, ModeFull, 1'b1, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b1, ModeZero, 1'b0, 1'b1, ModeFull, 1'b0, 1'b1},
      // five digits fall back to symbolic and fail
      '{cmsp_pkg::ChSeven, 1'b1, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChSeven, 1'b0, 1'b1, ModeZero, 1'b0, 1'b1, ModeZero, 1'b1, 1'b0},
      // u+s,g=X on a directory
      '{cmsp_pkg::ChU,     1'b1, 1'b0, 12'o0644, 1'b1, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChPlus,  1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChS,     1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChComma, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChG,     1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChEq,    1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChBigX,  1'b0, 1'b1, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      // zero byte as a whole string
      '{8'h00,             1'b1, 1'b1, ModeFull, 1'b0, 1'b1, ModeZero, 1'b1, 1'b0},
      // string ends inside who letters
      '{cmsp_pkg::ChU,     1'b1, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChG,     1'b0, 1'b1, ModeZero, 1'b0, 1'b1, ModeZero, 1'b1, 1'b0},
      // chained ops +t-x on a full mode, not a directory
      '{cmsp_pkg::ChPlus,  1'b1, 1'b0, ModeFull, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChT,     1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChMinus, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      '{cmsp_pkg::ChX,     1'b0, 1'b1, ModeZero, 1'b0, 1'b0, ModeZero, 1'b0, 1'b0},
      // extending past a result with a byte that fits no rule
      '{8'hff,             1'b0, 1'b1, ModeFull, 1'b1, 1'b1, ModeZero, 1'b1, 1'b0}
    };

    clear_parse();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < NumRows; i++)
      send_char(rows[i].ch, rows[i].first, rows[i].last, rows[i].smode, rows[i].dir,
                rows[i].typed, '{rows[i].want_mode, rows[i].want_bad, rows[i].want_octal},
                $urandom_range(0, 2));

    // let the directed results drain before the random part
    s_valid <= 1'b0;
    wait (expected_modes.size() == 0);
    @(negedge clk_i);

    while (chars_sent < NumRows + RandChars) begin
      fill_mode_string();
      quiet       = ($urandom_range(0, 3) == 0);
      sink_steady = quiet;
      for (j = 0; j < str_q.size(); j++) begin
        fst = (j == 0) && ($urandom_range(0, 19) != 0);
        lst = (j == str_q.size() - 1) || ($urandom_range(0, 19) == 0);
        r = $urandom_range(0, 9);
        smode = (r == 0) ? ModeZero : (r == 1) ? ModeFull
              : cmsp_pkg::mode_t'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (quiet || r < 75) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        send_char(str_q[j], fst, lst, smode, 1'($urandom_range(0, 1)), 1'b0, '0, gap);
      end
      strings_sent++;
      // sender holds off now and then until the parser has nothing in flight
      if (strings_sent % 40 == 0) begin
        s_valid <= 1'b0;
        wait (expected_modes.size() == 0);
        @(negedge clk_i);
      end
    end

    s_valid     <= 1'b0;
    sink_steady = 1'b0;
    wait (expected_modes.size() == 0);
    repeat (8) @(posedge clk_i);

    $display("sent %0d characters in %0d random strings plus %0d directed words",
             chars_sent, strings_sent, NumRows);
    $display("checked %0d result words: %0d octal, %0d rejected, %0d mismatches",
             results_seen, octal_seen, invalid_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_modes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
